@@ rtl/fpa_pkg.sv @@
// fpa_pkg: shared widths, operation codes and the pipeline stage record
// for the fixed-point unit; no dependencies
package fpa_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned FUNC_WIDTH = 5;
  // one quotient bit per cell: integer part plus fraction
  localparam int unsigned QUOT_WIDTH = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned PROD_WIDTH = 2 * DATA_WIDTH;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FN_ADD      = 5'd0,
    FN_SUB      = 5'd1,
    FN_MUL      = 5'd2,
    FN_DIV      = 5'd3,
    FN_LT       = 5'd4,
    FN_GT       = 5'd5,
    FN_LE       = 5'd6,
    FN_GE       = 5'd7,
    FN_EQ       = 5'd8,
    FN_NE       = 5'd9,
    FN_MIN      = 5'd10,
    FN_MAX      = 5'd11,
    FN_INC      = 5'd12,
    FN_DEC      = 5'd13,
    FN_TO_INT   = 5'd14,
    FN_FROM_INT = 5'd15,
    FN_SIGN     = 5'd16
  } func_t;

  typedef struct packed {
    logic                  valid;
    logic                  is_div;
    logic                  neg;
    logic                  dz;
    logic                  flag;
    logic [DATA_WIDTH-1:0] res;
    logic [DATA_WIDTH:0]   rem;
    logic [QUOT_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic [QUOT_WIDTH-1:0] quo;
  } stage_t;

endpackage

@@ rtl/fpa_if.sv @@
// fpa_in_if / fpa_out_if: valid-ready channels of the fixed-point unit
// depends on fpa_pkg
interface fpa_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [fpa_pkg::FUNC_WIDTH-1:0]        func;
  logic signed [fpa_pkg::DATA_WIDTH-1:0] a_raw;
  logic signed [fpa_pkg::DATA_WIDTH-1:0] b_raw;
  modport source (output valid, func, a_raw, b_raw, input ready);
  modport sink (input valid, func, a_raw, b_raw, output ready);
endinterface

interface fpa_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fpa_pkg::DATA_WIDTH-1:0] result_raw;
  logic                                  flag;
  logic                                  div_zero;
  modport source (output valid, result_raw, flag, div_zero, input ready);
  modport sink (input valid, result_raw, flag, div_zero, output ready);
endinterface

@@ rtl/fpa_front.sv @@
// fpa_front: entry stage, evaluates every operation except division and
// prepares the divider magnitudes; depends on fpa_pkg
module fpa_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [fpa_pkg::FUNC_WIDTH-1:0]     func,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] a,
  input  logic signed [fpa_pkg::DATA_WIDTH-1:0] b,
  output fpa_pkg::stage_t                    stage_r
);
  localparam int unsigned DW = fpa_pkg::DATA_WIDTH;
  localparam int unsigned FB = fpa_pkg::FRAC_BITS;

  fpa_pkg::stage_t             stage_nxt;
  logic signed [fpa_pkg::PROD_WIDTH-1:0] prod;
  logic signed [DW-1:0]        round_adj;
  logic signed [DW-1:0]        to_int_sum;
  logic [DW-1:0]               a_mag;
  logic [DW-1:0]               b_mag;
  logic                        lt;
  logic                        gt;

  assign prod = fpa_pkg::PROD_WIDTH'(a) * fpa_pkg::PROD_WIDTH'(b);
  assign lt = a < b;
  assign gt = a > b;
  // bias negative values so the arithmetic shift truncates toward zero
  assign round_adj = a[DW-1] ? DW'((64'd1 << FB) - 64'd1) : '0;
  assign to_int_sum = a + round_adj;
  assign a_mag = a[DW-1] ? DW'(-a) : DW'(a);
  assign b_mag = b[DW-1] ? DW'(-b) : DW'(b);

  always_comb begin
    stage_nxt        = '0;
    stage_nxt.valid  = in_valid;
    stage_nxt.num    = {a_mag, {FB{1'b0}}};
    stage_nxt.den    = b_mag;
    stage_nxt.neg    = a[DW-1] ^ b[DW-1];
    unique case (func)
      fpa_pkg::FN_ADD:      stage_nxt.res = DW'(a + b);
      fpa_pkg::FN_SUB:      stage_nxt.res = DW'(a - b);
      fpa_pkg::FN_MUL:      stage_nxt.res = prod[FB+DW-1:FB];
      fpa_pkg::FN_DIV: begin
        stage_nxt.is_div = (b != '0);
        stage_nxt.dz     = (b == '0);
      end
      fpa_pkg::FN_LT:       stage_nxt.flag = lt;
      fpa_pkg::FN_GT:       stage_nxt.flag = gt;
      fpa_pkg::FN_LE:       stage_nxt.flag = !gt;
      fpa_pkg::FN_GE:       stage_nxt.flag = !lt;
      fpa_pkg::FN_EQ:       stage_nxt.flag = (a == b);
      fpa_pkg::FN_NE:       stage_nxt.flag = (a != b);
      fpa_pkg::FN_MIN:      stage_nxt.res = lt ? a : b;
      fpa_pkg::FN_MAX:      stage_nxt.res = gt ? a : b;
      fpa_pkg::FN_INC:      stage_nxt.res = DW'(a + 1);
      fpa_pkg::FN_DEC:      stage_nxt.res = DW'(a - 1);
      fpa_pkg::FN_TO_INT:   stage_nxt.res = DW'(to_int_sum >>> FB);
      fpa_pkg::FN_FROM_INT: stage_nxt.res = DW'(a << FB);
      fpa_pkg::FN_SIGN:     stage_nxt.flag = a[DW-1];
      default:              stage_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end
endmodule

@@ rtl/fpa_cell.sv @@
// fpa_cell: one restoring-division cell, settles one quotient bit and
// hands the record to its neighbour; depends on fpa_pkg
module fpa_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fpa_pkg::stage_t stage_in,
  output fpa_pkg::stage_t stage_r
);
  localparam int unsigned DW = fpa_pkg::DATA_WIDTH;
  localparam int unsigned QW = fpa_pkg::QUOT_WIDTH;

  fpa_pkg::stage_t stage_nxt;
  logic [DW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {stage_in.rem[DW-1:0], stage_in.num[QW-1]};
  assign ge     = rem_sh >= {1'b0, stage_in.den};

  always_comb begin
    stage_nxt     = stage_in;
    stage_nxt.rem = ge ? rem_sh - {1'b0, stage_in.den} : rem_sh;
    stage_nxt.num = {stage_in.num[QW-2:0], 1'b0};
    stage_nxt.quo = {stage_in.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end
endmodule

@@ rtl/fixed_point_alu.sv @@
// fixed_point_alu: signed q24.8 arithmetic unit, one result per transaction
// pipeline: entry stage, then the row of division cells, then the output register
// throughput: one transaction per cycle unless a finished result waits for out_ch.ready; the row has 40 division cells
// every operation rides the same row so results leave in order
// reset: synchronous active-low rst_n empties the pipeline, no other state
// depends on fpa_pkg, fpa_if, fpa_front, fpa_cell
module fixed_point_alu (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);
  localparam int unsigned DW = fpa_pkg::DATA_WIDTH;
  localparam int unsigned QW = fpa_pkg::QUOT_WIDTH;

  // chain[0] is the entry stage, chain[QW] the last division cell
  fpa_pkg::stage_t       chain [0:QW];
  logic                  en;
  logic                  out_valid_r;
  logic [DW-1:0]         out_res_r;
  logic                  out_flag_r;
  logic                  out_dz_r;
  logic [DW-1:0]         res_nxt;

  // whole row advances unless a finished result is held back
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .func     (in_ch.func),
    .a        (in_ch.a_raw),
    .b        (in_ch.b_raw),
    .stage_r  (chain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    fpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .stage_in (chain[i]),
      .stage_r  (chain[i+1])
    );
  end

  // division quotient gets its sign back here, wrapping to the word width
  always_comb begin
    res_nxt = chain[QW].res;
    if (chain[QW].is_div) begin
      res_nxt = chain[QW].neg ? DW'(-chain[QW].quo) : chain[QW].quo[DW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[QW].valid;
      out_res_r   <= res_nxt;
      out_flag_r  <= chain[QW].flag;
      out_dz_r    <= chain[QW].dz;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_raw = out_res_r;
  assign out_ch.flag       = out_flag_r;
  assign out_ch.div_zero   = out_dz_r;
endmodule
